>>> src/lfcc_pkg.sv
// Shared constants and types for the line framer with CRC-16/ARC check.
// Used by line_frame_crc_checker_unit and lfcc_checker; no dependencies.
package lfcc_pkg;

	localparam int LINE_BYTES = 64;
	localparam int ADDR_W     = $clog2(LINE_BYTES);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_LOW_X = 8'h78;

	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_SEQ    = 2'd1,
		KIND_BODY   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		FS_VALID  = 2'd0,
		FS_SYNTAX = 2'd1,
		FS_CRC    = 2'd2
	} fstat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_EX,
		ST_DECIDE,
		ST_CRC_RD,
		ST_CRC_EX,
		ST_CRC_BIT,
		ST_HEX_RD,
		ST_HEX_EX,
		ST_CHECK,
		ST_STAT,
		ST_EMIT_RD,
		ST_EMIT_EX,
		ST_OUT
	} state_t;

endpackage

>>> src/line_frame_crc_checker_unit.sv
// Line framer: stores received characters and checks each line as seq:body:checksum.
// Depends on lfcc_pkg and lfcc_ram (line store).
//
// Usage
//   Input channel (in_valid/in_ready, char_in) takes one received character per item.
//   Output channel (out_valid/out_ready) gives result items: a status item for each
//   finished line, then, for a valid line, its sequence bytes and body bytes; last
//   marks the final item of the line.
//   Ordinary characters, backspace and DEL are taken while idle; in_ready stays high.
//   CR or LF starts the line check, run by one sequencer over the single read port
//   of the line store: a colon scan over the stored bytes, a bit-serial CRC over the
//   body bytes (one CRC bit per cycle), a read of the checksum characters,
//   bookkeeping, then the status item and the byte items.
//   in_ready stays low from the line end until the last item of the line is taken.
//   Each result item sits in the output register until out_ready; a stalled
//   receiver simply holds the sequencer there.
//   Reset clears the fill count and the sequencer; the store itself is not cleared,
//   and only entries written since the line began are ever read.
module line_frame_crc_checker_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] item_kind,
	output logic [7:0] data_byte,
	output logic [1:0] frame_status,
	output logic       seq_given,
	output logic       last
);

	import lfcc_pkg::*;

	state_t state_q, state_d;

	logic [ADDR_W-1:0] fill_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] len_q;
	logic [1:0]        colons_q;
	logic [ADDR_W-1:0] c1_q, c2_q;
	logic [ADDR_W-1:0] seq_end_q, bstart_q, bend_q;
	logic [15:0]       crc_q;
	logic [15:0]       hex_q;
	logic [2:0]        bit_q;
	fstat_t            status_q;
	logic              seqg_q;
	kind_t             ekind_q;

	kind_t             okind_q;
	logic [7:0]        odata_q;
	fstat_t            ostat_q;
	logic              oseqg_q;
	logic              olast_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	logic              in_acc, out_acc;
	logic              is_eol, is_erase;
	logic [4:0]        hex_d;
	logic [ADDR_W:0]   idx_inc;
	logic [ADDR_W-1:0] hex_off;

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b0, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign is_eol   = (char_in == CH_CR) || (char_in == CH_LF);
	assign is_erase = (char_in == CH_BS) || (char_in == CH_DEL);
	assign hex_d    = hex_val(ram_rdata);
	assign idx_inc  = {1'b0, idx_q} + 1'b1;
	assign hex_off  = idx_q - c2_q;

	lfcc_ram #(
		.WIDTH(8),
		.DEPTH(LINE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q),
		.wdata(char_in),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && is_eol) begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				state_d = (idx_q == fill_q) ? ST_DECIDE : ST_SCAN_EX;
			end
			ST_SCAN_EX: begin
				state_d = (ram_rdata == CH_NUL) ? ST_DECIDE : ST_SCAN_RD;
			end
			ST_DECIDE: begin
				state_d = (colons_q == 2'd2) ? ST_CRC_RD : ST_STAT;
			end
			ST_CRC_RD: begin
				state_d = (idx_q == bend_q) ? ST_HEX_RD : ST_CRC_EX;
			end
			ST_CRC_EX: begin
				state_d = ST_CRC_BIT;
			end
			ST_CRC_BIT: begin
				if (bit_q == 3'd7) begin
					state_d = ST_CRC_RD;
				end
			end
			ST_HEX_RD: begin
				state_d = (idx_q == len_q) ? ST_CHECK : ST_HEX_EX;
			end
			ST_HEX_EX: begin
				// "0x" prefix: second char is x while the value so far is a lone zero
				if (!hex_d[4] || (hex_off == ADDR_W'(2) && hex_q == 16'd0 &&
				    (ram_rdata | 8'h20) == CH_LOW_X)) begin
					state_d = ST_HEX_RD;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = ST_STAT;
			end
			ST_STAT: begin
				state_d = ST_OUT;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_EX;
			end
			ST_EMIT_EX: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_acc) begin
					state_d = olast_q ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// handshake and store port controls
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = idx_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ram_we   = in_acc && !is_eol && !is_erase &&
				           (fill_q < ADDR_W'(LINE_BYTES - 1));
			end
			ST_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
				ram_raddr = idx_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_acc) begin
				if (is_erase) begin
					if (fill_q != '0) begin
						fill_q <= fill_q - 1'b1;
					end
				end else if (ram_we) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (state_q == ST_OUT && out_acc && olast_q) begin
				fill_q <= '0;
			end
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q    <= '0;
				colons_q <= 2'd0;
			end
			ST_SCAN_RD: begin
				len_q <= idx_q;
			end
			ST_SCAN_EX: begin
				if (ram_rdata != CH_NUL) begin
					if (ram_rdata == CH_COLON) begin
						if (colons_q == 2'd0) begin
							c1_q <= idx_q;
						end
						if (colons_q == 2'd1) begin
							c2_q <= idx_q;
						end
						if (colons_q != 2'd3) begin
							colons_q <= colons_q + 2'd1;
						end
					end
					idx_q <= ADDR_W'(idx_inc);
				end
			end
			ST_DECIDE: begin
				crc_q    <= 16'd0;
				hex_q    <= 16'd0;
				status_q <= FS_VALID;
				case (colons_q)
					2'd0: begin
						seqg_q    <= 1'b0;
						seq_end_q <= '0;
						bstart_q  <= '0;
						bend_q    <= len_q;
					end
					2'd1: begin
						seqg_q    <= 1'b1;
						seq_end_q <= c1_q;
						bstart_q  <= c1_q + 1'b1;
						bend_q    <= len_q;
					end
					2'd2: begin
						seqg_q    <= 1'b1;
						seq_end_q <= c1_q;
						bstart_q  <= c1_q + 1'b1;
						bend_q    <= c2_q;
						idx_q     <= c1_q + 1'b1;
					end
					default: begin
						seqg_q   <= 1'b0;
						status_q <= FS_SYNTAX;
					end
				endcase
			end
			ST_CRC_RD: begin
				if (idx_q == bend_q) begin
					idx_q <= c2_q + 1'b1;
				end
			end
			ST_CRC_EX: begin
				crc_q <= crc_q ^ {8'd0, ram_rdata};
				bit_q <= 3'd0;
			end
			ST_CRC_BIT: begin
				crc_q <= crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
				bit_q <= bit_q + 3'd1;
				if (bit_q == 3'd7) begin
					idx_q <= ADDR_W'(idx_inc);
				end
			end
			ST_HEX_EX: begin
				if (!hex_d[4]) begin
					hex_q <= {hex_q[11:0], hex_d[3:0]};
				end
				idx_q <= ADDR_W'(idx_inc);
			end
			ST_CHECK: begin
				status_q <= (hex_q != crc_q) ? FS_CRC : FS_VALID;
			end
			ST_STAT: begin
				okind_q <= KIND_STATUS;
				odata_q <= 8'd0;
				ostat_q <= status_q;
				oseqg_q <= seqg_q;
				olast_q <= (status_q != FS_VALID) ||
				           (seq_end_q == '0 && bend_q <= bstart_q);
				if (seq_end_q != '0) begin
					idx_q   <= '0;
					ekind_q <= KIND_SEQ;
				end else begin
					idx_q   <= bstart_q;
					ekind_q <= KIND_BODY;
				end
			end
			ST_EMIT_EX: begin
				okind_q <= ekind_q;
				odata_q <= ram_rdata;
				ostat_q <= FS_VALID;
				oseqg_q <= 1'b0;
				if (ekind_q == KIND_SEQ) begin
					olast_q <= (idx_inc == {1'b0, seq_end_q}) && (bend_q <= bstart_q);
					if (idx_inc == {1'b0, seq_end_q}) begin
						idx_q   <= bstart_q;
						ekind_q <= KIND_BODY;
					end else begin
						idx_q <= ADDR_W'(idx_inc);
					end
				end else begin
					olast_q <= (idx_inc == {1'b0, bend_q});
					idx_q   <= ADDR_W'(idx_inc);
				end
			end
			default: begin
				bit_q <= bit_q;
			end
		endcase
	end

	assign item_kind    = okind_q;
	assign data_byte    = odata_q;
	assign frame_status = ostat_q;
	assign seq_given    = oseqg_q;
	assign last         = olast_q;

endmodule

>>> src/lfcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/lfcc_checker.sv
// Port-level checks for line_frame_crc_checker_unit, bound to the top level.
// Depends on lfcc_pkg.
module lfcc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] item_kind,
	input logic [1:0] frame_status,
	input logic       seq_given,
	input logic       last
);

	import lfcc_pkg::*;

	// a pending result item is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// input side is closed while any result of a line is pending
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted during line output");

	// a failed line ends at its status item
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == KIND_STATUS && frame_status != FS_VALID |-> last)
		else $error("failed line status not marked last");

	// byte items carry no status information
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind != KIND_STATUS |-> frame_status == FS_VALID && !seq_given)
		else $error("byte item carries status fields");

	// block reopens right after the final item of a line
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready)
		else $error("input not reopened after last item");

endmodule

bind line_frame_crc_checker_unit lfcc_checker u_lfcc_checker (.*);

>>> tb/testbench.sv
// Testbench for line_frame_crc_checker_unit: drives received characters, predicts the
// status, sequence and body items of each line and checks them item by item.
// Depends on lfcc_pkg and the line_frame_crc_checker_unit RTL.
`timescale 1ns / 100ps

module testbench;
	import lfcc_pkg::*;

	// must outlast the check of a full 63-byte line before its first item
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 100;
	localparam int MAX_REPORTS = 30;

	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		fstat_t     status;
		logic       seqg;
		logic       last;
	} frame_item_t;

	// hold: sender waits here until every expected item has come back
	typedef struct {
		bit         hold;
		logic [7:0] ch;
	} char_slot_t;

	typedef enum {FORM_GOOD, FORM_BAD, FORM_SEQ_ONLY, FORM_BARE} frame_form_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_in = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] item_kind;
	logic [7:0] data_byte;
	logic [1:0] frame_status;
	logic       seq_given;
	logic       last;

	char_slot_t  char_q[$];
	frame_item_t frame_items_q[$];

	// predictor copy of the line store
	logic [7:0] line_buf[LINE_BYTES];
	int         line_fill = 0;

	int  stim_chars = 0;
	int  issued = 0;
	int  taken = 0;
	int  checked = 0;
	int  errors = 0;
	int  lines_done = 0;
	int  lines_valid = 0;
	int  lines_syntax = 0;
	int  lines_crc_bad = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  quiet_cycles = 0;
	bit  send_quiet = 1'b0;
	bit  recv_quiet = 1'b0;
	bit  in_took = 1'b0;
	bit  out_took = 1'b0;

	line_frame_crc_checker_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_in(char_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_kind(item_kind),
		.data_byte(data_byte),
		.frame_status(frame_status),
		.seq_given(seq_given),
		.last(last)
	);

	always #1 clk = ~clk;

	function automatic logic [15:0] crc16_arc(input logic [7:0] bytes[$]);
		logic [15:0] crc;
		crc = 16'h0000;
		foreach (bytes[i]) begin
			crc = crc ^ {8'h00, bytes[i]};
			repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
		end
		return crc;
	endfunction

	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// any byte that is stored as-is and is not a colon or NUL
	function automatic logic [7:0] pick_plain();
		logic [7:0] c;
		c = CH_NUL;
		while (c == CH_NUL || c == CH_BS || c == CH_LF || c == CH_CR ||
				c == CH_COLON || c == CH_DEL)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// ---------------- prediction ----------------

	task automatic close_line();
		int          len, colons, c1, c2, seq_end, body_start, body_end, i, n, k;
		bit          done;
		logic [7:0]  c;
		logic [3:0]  nib;
		logic [15:0] given;
		logic [7:0]  body[$];
		fstat_t      st;
		logic        seqg;
		frame_item_t it;

		len = 0;
		while (len < line_fill && line_buf[len] != CH_NUL)
			len++;
		colons = 0;
		c1 = 0;
		c2 = 0;
		for (i = 0; i < len; i++) begin
			if (line_buf[i] == CH_COLON) begin
				if (colons == 0)
					c1 = i;
				else if (colons == 1)
					c2 = i;
				colons++;
			end
		end
		st = FS_VALID;
		seqg = 1'b0;
		seq_end = 0;
		body_start = 0;
		body_end = len;
		if (colons >= 3) begin
			st = FS_SYNTAX;
		end else if (colons >= 1) begin
			seqg = 1'b1;
			seq_end = c1;
			body_start = c1 + 1;
			if (colons == 2) begin
				body_end = c2;
				for (i = body_start; i < body_end; i++)
					body.push_back(line_buf[i]);
				// hex text: optional 0x/0X, digits up to first non-hex char, mod 2^16
				i = c2 + 1;
				given = 16'h0000;
				if (i + 1 < len && line_buf[i] == "0" && (line_buf[i + 1] | 8'h20) == CH_LOW_X)
					i += 2;
				done = 1'b0;
				while (!done && i < len) begin
					c = line_buf[i];
					nib = 4'h0;
					if (c >= "0" && c <= "9")
						nib = 4'(c - "0");
					else if (c >= "a" && c <= "f")
						nib = 4'(c - "a" + 8'd10);
					else if (c >= "A" && c <= "F")
						nib = 4'(c - "A" + 8'd10);
					else
						done = 1'b1;
					if (!done)
						given = {given[11:0], nib};
					i++;
				end
				if (given != crc16_arc(body))
					st = FS_CRC;
			end
		end

		lines_done++;
		case (st)
			FS_VALID:  lines_valid++;
			FS_SYNTAX: lines_syntax++;
			default:   lines_crc_bad++;
		endcase

		it.kind = KIND_STATUS;
		it.data = 8'h00;
		it.status = st;
		it.seqg = (st == FS_SYNTAX) ? 1'b0 : seqg;
		if (st != FS_VALID || (seq_end == 0 && body_end <= body_start)) begin
			it.last = 1'b1;
			frame_items_q.push_back(it);
		end else begin
			n = 1 + seq_end + (body_end - body_start);
			it.last = 1'b0;
			frame_items_q.push_back(it);
			k = 1;
			it.status = FS_VALID;
			it.seqg = 1'b0;
			for (i = 0; i < body_end; i++) begin
				if (i < seq_end || i >= body_start) begin
					it.kind = (i < seq_end) ? KIND_SEQ : KIND_BODY;
					it.data = line_buf[i];
					it.last = (k == n - 1);
					frame_items_q.push_back(it);
					k++;
				end
			end
		end
	endtask

	task automatic absorb_char(input logic [7:0] c);
		if (c == CH_LF || c == CH_CR) begin
			close_line();
			line_fill = 0;
		end else if (c == CH_BS || c == CH_DEL) begin
			if (line_fill > 0)
				line_fill--;
		end else if (line_fill < LINE_BYTES - 1) begin
			line_buf[line_fill] = c;
			line_fill++;
		end
	endtask

	// ---------------- stimulus ----------------

	task automatic push_char(input logic [7:0] c);
		char_slot_t s;
		s.hold = 1'b0;
		s.ch = c;
		char_q.push_back(s);
		stim_chars++;
	endtask

	task automatic push_hold();
		char_slot_t s;
		s.hold = 1'b1;
		s.ch = 8'h00;
		char_q.push_back(s);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	// now and then a mistyped char erased by BS or DEL before the intended one
	task automatic push_typed(input logic [7:0] c);
		if ($urandom_range(0, 11) == 0) begin
			push_char(pick_plain());
			push_char($urandom_range(0, 1) ? CH_BS : CH_DEL);
		end
		push_char(c);
	endtask

	task automatic push_checksum(input logic [15:0] v);
		int         nd, min_nd, i;
		logic [3:0] d;

		case ($urandom_range(0, 3))
			1: push_text("0x");
			2: push_text("0X");
			default: ;
		endcase
		min_nd = (v >= 16'h1000) ? 4 : (v >= 16'h0100) ? 3 : (v >= 16'h0010) ? 2 : 1;
		nd = $urandom_range(1, 4);
		if (nd < min_nd)
			nd = min_nd;
		// extra leading digits shift out of the 16-bit value
		if ($urandom_range(0, 5) == 0)
			nd += $urandom_range(1, 2);
		if (v == 16'h0000 && $urandom_range(0, 2) == 0)
			nd = 0;
		for (i = nd - 1; i >= 0; i--) begin
			d = (i < 4) ? v[i * 4 +: 4] : 4'($urandom_range(0, 15));
			if (d < 10)
				push_char(8'("0" + d));
			else
				push_char(8'(($urandom_range(0, 1) ? "A" : "a") + d - 10));
		end
		if ($urandom_range(0, 5) == 0)
			push_text($urandom_range(0, 1) ? "z7" : " ");
	endtask

	task automatic push_frame(input int seq_len, input int body_len, input frame_form_t form);
		logic [7:0]  body[$];
		logic [7:0]  c;
		logic [15:0] crc;

		for (int i = 0; i < seq_len; i++)
			push_typed(pick_plain());
		if (form != FORM_BARE)
			push_char(CH_COLON);
		for (int i = 0; i < body_len; i++) begin
			c = pick_plain();
			body.push_back(c);
			push_typed(c);
		end
		if (form == FORM_GOOD || form == FORM_BAD) begin
			crc = crc16_arc(body);
			if (form == FORM_BAD)
				crc = crc ^ 16'($urandom_range(1, 65535));
			push_char(CH_COLON);
			push_checksum(crc);
		end
		push_char($urandom_range(0, 1) ? CH_LF : CH_CR);
	endtask

	task automatic push_noise_line();
		int n;
		n = $urandom_range(1, 12);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0: push_char(CH_COLON);
				1: push_char($urandom_range(0, 1) ? CH_BS : CH_DEL);
				2: push_char(CH_NUL);
				3: push_char(8'($urandom_range(0, 255)));
				default: push_char(pick_plain());
			endcase
		end
		push_char(CH_LF);
	endtask

	// ---------------- driver and monitor ----------------

	always @(negedge clk) begin
		logic       nv;
		logic [7:0] nc;
		char_slot_t s;

		nv = in_valid;
		nc = char_in;
		if (arst_n && (!in_valid || in_took)) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (char_q.size() != 0) begin
				if (char_q[0].hold) begin
					if (frame_items_q.size() == 0 && issued == taken)
						void'(char_q.pop_front());
				end else begin
					s = char_q.pop_front();
					nv = 1'b1;
					nc = s.ch;
					issued++;
					if ($urandom_range(0, 39) == 0)
						send_quiet = !send_quiet;
					gap_left = pick_gap(send_quiet);
				end
			end
		end
		in_valid <= nv;
		char_in <= nc;
	end

	always @(negedge clk) begin
		logic rdy;
		rdy = 1'b0;
		if (arst_n) begin
			if (stall_left == 0 && (out_took || $urandom_range(0, 15) == 0)) begin
				if ($urandom_range(0, 39) == 0)
					recv_quiet = !recv_quiet;
				stall_left = pick_gap(recv_quiet);
			end
			if (stall_left > 0)
				stall_left--;
			else
				rdy = 1'b1;
		end
		out_ready <= rdy;
	end

	task automatic flag_field(input string field, input logic [7:0] want, input logic [7:0] got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected %02h, actual %02h", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		frame_item_t want;

		in_took <= in_valid && in_ready;
		out_took <= out_valid && out_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (frame_items_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected item: expected none, actual kind %0d data %02h",
							$time, item_kind, data_byte);
				end else begin
					want = frame_items_q.pop_front();
					checked++;
					if (item_kind !== want.kind)
						flag_field("item_kind", 8'(want.kind), 8'(item_kind));
					if (data_byte !== want.data)
						flag_field("data_byte", want.data, data_byte);
					if (frame_status !== want.status)
						flag_field("frame_status", 8'(want.status), 8'(frame_status));
					if (seq_given !== want.seqg)
						flag_field("seq_given", 8'(want.seqg), 8'(seq_given));
					if (last !== want.last)
						flag_field("last", 8'(want.last), 8'(last));
				end
			end
			if (in_valid && in_ready) begin
				taken++;
				absorb_char(char_in);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin
		int  pick, blen;
		bit  long_done;

		long_done = 1'b0;

		// directed lines
		push_char(CH_BS);                 // erase on an empty line
		push_char(CH_LF);                 // empty line
		push_char(CH_COLON);
		push_char(CH_CR);                 // lone colon: seq part present, nothing to send
		push_text(":::");
		push_char(CH_LF);                 // too many colons
		push_text("7q");
		push_char(CH_DEL);
		push_text("::");
		push_char(CH_LF);                 // trailing colon, empty checksum reads as 0
		push_char(8'hFF);
		push_char(CH_NUL);
		push_text("q");
		push_char(CH_CR);                 // content stops at the NUL
		push_text(":A:0x30c0");
		push_char(CH_LF);                 // CRC of "A" with prefix
		push_text(":A:1");
		push_char(CH_LF);                 // checksum mismatch
		push_hold();

		// random lines, mostly well formed
		while (stim_chars < 125) begin
			if ($urandom_range(0, 7) == 0)
				push_hold();
			pick = $urandom_range(0, 99);
			blen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
			if (!long_done && stim_chars > 40) begin
				// overflow: chars past 63 dropped, then one edited at the end
				repeat (66)
					push_char(pick_plain());
				push_char(CH_BS);
				push_char(pick_plain());
				push_char(CH_LF);
				long_done = 1'b1;
			end else if (pick < 55)
				push_frame($urandom_range(0, 3), blen, FORM_GOOD);
			else if (pick < 65)
				push_frame($urandom_range(0, 3), blen, FORM_BAD);
			else if (pick < 75)
				push_frame($urandom_range(0, 3), blen, FORM_SEQ_ONLY);
			else if (pick < 82)
				push_frame(0, blen, FORM_BARE);
			else
				push_noise_line();
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (char_q.size() != 0 || issued != taken || frame_items_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d chars over %0d lines (%0d valid, %0d syntax, %0d bad checksum),",
			issued, lines_done, lines_valid, lines_syntax, lines_crc_bad);
		$display("with edits, NUL bytes, an overflowed line and random stalls; %0d items checked.",
			checked);
		if (errors == 0 && frame_items_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
